/* src/gossip_membership_table_assert.svh */
// Assertion macros used by the checker file.
`ifndef GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH
`define GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define GMT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the following cycle.
`define GMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/gmt_pkg.sv */
`timescale 1ns / 1ps
package gmt_pkg;
    localparam int MaxNodes = 16;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int CntW = 5;

    localparam logic [1:0] ST_ALIVE = 2'd0;
    localparam logic [1:0] ST_SUSPECT = 2'd1;
    localparam logic [1:0] ST_DEAD = 2'd2;
    localparam logic [1:0] ST_RSVD = 2'd3;

    localparam logic [2:0] OP_SEED = 3'd0;
    localparam logic [2:0] OP_RUMOR = 3'd1;
    localparam logic [2:0] OP_SUSPECT = 3'd2;
    localparam logic [2:0] OP_DEAD = 3'd3;
    localparam logic [2:0] OP_ALIVE = 3'd4;

    localparam logic [1:0] CFG_SELF_NODE = 2'd0;
    localparam logic [1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [1:0] CFG_QUAR = 2'd2;

    // One request after decode, as held in the queue.
    typedef struct packed {
        logic [2:0]  op;
        logic        in_range;
        logic [3:0]  node;
        logic [1:0]  cst;
        logic [63:0] cinc;
        logic [15:0] cport;
        logic [31:0] now;
    } req_t;
endpackage

/* src/gmt_front.sv */
`timescale 1ns / 1ps
module gmt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    op,
    input  logic [3:0]    node,
    input  logic [1:0]    claimed_state,
    input  logic [63:0]   claimed_incarnation,
    input  logic [15:0]   claimed_port,
    input  logic [31:0]   now,
    output logic          q_valid,
    input  logic          q_ready,
    output gmt_pkg::req_t q_req
);
    import gmt_pkg::*;

    // Two-entry queue decouples the input from the table engine.
    req_t       mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;
    req_t       dec;

    always_comb
    begin
        dec.op = op;
        dec.in_range = ({28'd0, node} < MaxNodes);
        dec.node = node;
        dec.cst = claimed_state;
        dec.cinc = claimed_incarnation;
        dec.cport = claimed_port;
        dec.now = now;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_req = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= dec;
    end
endmodule

/* src/gmt_back.sv */
`timescale 1ns / 1ps
module gmt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  gmt_pkg::req_t q_req,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          changed,
    output logic          entry_present,
    output logic [1:0]    entry_state,
    output logic [63:0]   entry_incarnation,
    output logic [15:0]   entry_port,
    output logic          quarantined,
    output logic [4:0]    alive_count,
    output logic [4:0]    member_count,
    output logic          degraded
);
    import gmt_pkg::*;

    logic [MaxNodes-1:0] pres_reg;
    logic [1:0]          st_reg   [MaxNodes];
    logic [63:0]         inc_reg  [MaxNodes];
    logic [15:0]         port_reg [MaxNodes];
    logic [31:0]         join_reg [MaxNodes];
    logic [3:0]          self_reg;
    logic [15:0]         sport_reg;
    logic [31:0]         quar_reg;
    logic [CntW-1:0]     alive_reg, alive_next, memb_reg, memb_next;
    logic                ov_reg;

    logic [NodeW-1:0] idx;
    logic             self_in, here, chg, wr;
    logic [1:0]       cur_st, n_st;
    logic [63:0]      cur_inc, n_inc, top, nxt;
    logic [15:0]      cur_port, n_port;
    logic [31:0]      cur_join, n_join;
    logic             n_pres;
    logic             take;

    assign idx = q_req.node[NodeW-1:0];
    assign self_in = ({28'd0, self_reg} < MaxNodes);
    assign here = q_req.in_range && pres_reg[idx];
    assign cur_st = st_reg[idx];
    assign cur_inc = inc_reg[idx];
    assign cur_port = port_reg[idx];
    assign cur_join = join_reg[idx];
    assign top = (cur_inc > q_req.cinc) ? cur_inc : q_req.cinc;
    assign nxt = (&top) ? top : top + 64'd1;

    assign q_ready = !ov_reg || out_ready;
    assign take = q_valid && q_ready;

    // Entry update for one request.
    always_comb
    begin
        n_pres = here;
        n_st = cur_st;
        n_inc = cur_inc;
        n_port = cur_port;
        n_join = cur_join;
        chg = 1'b0;
        wr = 1'b0;
        if (q_req.in_range)
        begin
            unique case (q_req.op)
                OP_SEED:
                    if (q_req.node != self_reg)
                    begin
                        wr = 1'b1;
                        n_pres = 1'b1;
                        n_st = ST_ALIVE;
                        n_inc = '0;
                        n_port = q_req.cport;
                        n_join = q_req.now;
                    end
                OP_RUMOR:
                    if (q_req.cst != ST_RSVD)
                    begin
                        if (!here)
                        begin
                            if (q_req.cst == ST_ALIVE)
                            begin
                                wr = 1'b1;
                                n_pres = 1'b1;
                                n_st = ST_ALIVE;
                                n_inc = q_req.cinc;
                                n_port = q_req.cport;
                                n_join = q_req.now;
                                chg = 1'b1;
                            end
                        end
                        else if (q_req.cinc < cur_inc)
                            wr = 1'b0;
                        else if (q_req.cinc == cur_inc && q_req.cst == cur_st)
                            wr = 1'b0;
                        else if (q_req.node == self_reg && q_req.cst != ST_ALIVE)
                        begin
                            wr = 1'b1;
                            if (cur_inc <= q_req.cinc && nxt != cur_inc)
                            begin
                                n_inc = nxt;
                                chg = 1'b1;
                            end
                            if (cur_st != ST_ALIVE)
                            begin
                                n_st = ST_ALIVE;
                                chg = 1'b1;
                            end
                        end
                        else
                        begin
                            wr = 1'b1;
                            chg = (cur_st != q_req.cst) || (cur_inc != q_req.cinc);
                            n_st = q_req.cst;
                            n_inc = q_req.cinc;
                            if (cur_port == 16'd0 && q_req.cport != 16'd0)
                                n_port = q_req.cport;
                        end
                    end
                OP_SUSPECT:
                    if (here && cur_st == ST_ALIVE)
                    begin
                        wr = 1'b1;
                        n_st = ST_SUSPECT;
                        chg = 1'b1;
                    end
                OP_DEAD:
                    if (here && cur_st != ST_DEAD)
                    begin
                        wr = 1'b1;
                        n_st = ST_DEAD;
                        chg = 1'b1;
                    end
                OP_ALIVE:
                    if (here && !(cur_st == ST_ALIVE && cur_inc >= q_req.cinc))
                    begin
                        wr = 1'b1;
                        if (cur_st != ST_ALIVE)
                            n_join = q_req.now;
                        n_st = ST_ALIVE;
                        n_inc = q_req.cinc;
                        chg = 1'b1;
                    end
                default:
                    wr = 1'b0;
            endcase
        end
    end

    // Counts follow from the old and new membership of the one entry touched.
    always_comb
    begin
        logic oa, na;
        oa = here && cur_st == ST_ALIVE;
        na = n_pres && n_st == ST_ALIVE;
        memb_next = memb_reg + CntW'(n_pres && !here);
        alive_next = alive_reg + CntW'(na && !oa) - CntW'(oa && !na);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pres_reg <= '0;
            self_reg <= '0;
            sport_reg <= '0;
            quar_reg <= '0;
            alive_reg <= '0;
            memb_reg <= '0;
            ov_reg <= 1'b0;
            for (int i = 0; i < MaxNodes; i++)
            begin
                st_reg[i] <= ST_ALIVE;
                inc_reg[i] <= '0;
                port_reg[i] <= '0;
                join_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SELF_NODE:
                begin
                    self_reg <= cfg_data[3:0];
                    for (int i = 0; i < MaxNodes; i++)
                    begin
                        st_reg[i] <= ST_ALIVE;
                        inc_reg[i] <= '0;
                        join_reg[i] <= '0;
                        pres_reg[i] <= ({28'd0, cfg_data[3:0]} == i);
                        port_reg[i] <= ({28'd0, cfg_data[3:0]} == i) ? sport_reg : 16'd0;
                    end
                    alive_reg <= ({28'd0, cfg_data[3:0]} < MaxNodes) ? CntW'(1) : '0;
                    memb_reg <= ({28'd0, cfg_data[3:0]} < MaxNodes) ? CntW'(1) : '0;
                end
                CFG_SELF_PORT:
                begin
                    sport_reg <= cfg_data[15:0];
                    if (self_in && pres_reg[self_reg[NodeW-1:0]])
                        port_reg[self_reg[NodeW-1:0]] <= cfg_data[15:0];
                end
                CFG_QUAR:
                    quar_reg <= cfg_data;
                default:
                    quar_reg <= quar_reg;
            endcase
        end
        else
        begin
            if (take)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (take && wr)
            begin
                pres_reg[idx] <= n_pres;
                st_reg[idx] <= n_st;
                inc_reg[idx] <= n_inc;
                port_reg[idx] <= n_port;
                join_reg[idx] <= n_join;
                alive_reg <= alive_next;
                memb_reg <= memb_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            logic [31:0] age;
            logic [4:0] a, m;
            age = q_req.now - n_join;
            a = wr ? alive_next : alive_reg;
            m = wr ? memb_next : memb_reg;
            changed <= chg;
            entry_present <= n_pres;
            entry_state <= n_pres ? n_st : 2'd0;
            entry_incarnation <= n_pres ? n_inc : 64'd0;
            entry_port <= n_pres ? n_port : 16'd0;
            quarantined <= n_pres && quar_reg != 32'd0 && n_st == ST_ALIVE && age < quar_reg;
            alive_count <= a;
            member_count <= m;
            degraded <= (m == 5'd0) || (a < ({1'b0, m[4:1]} + 5'd1));
        end
    end

    assign out_valid = ov_reg;
endmodule

/* src/gossip_membership_table.sv */
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// in       | in_valid / in_ready    | op node claimed_state claimed_incarnation claimed_port now
// out      | out_valid / out_ready  | changed entry_* quarantined counts degraded
// cfg      | cfg_we                 | cfg_index cfg_data
//
// A request accepted into the two-entry input queue is taken from it by the table
// engine, which registers its result in the output register; the result is then held
// until out_ready takes it.
// One request a cycle is sustained while the output is taken every cycle; the single
// read-modify-write of one table entry per cycle sets this figure.
// Reset is asynchronous and leaves the table empty, self included, until self_node
// is written. A stalled output holds the engine; the queue keeps taking requests
// until it is full.
module gossip_membership_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [3:0]  node,
    input  logic [1:0]  claimed_state,
    input  logic [63:0] claimed_incarnation,
    input  logic [15:0] claimed_port,
    input  logic [31:0] now,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        changed,
    output logic        entry_present,
    output logic [1:0]  entry_state,
    output logic [63:0] entry_incarnation,
    output logic [15:0] entry_port,
    output logic        quarantined,
    output logic [4:0]  alive_count,
    output logic [4:0]  member_count,
    output logic        degraded
);
    import gmt_pkg::*;

    // The front end decodes and queues requests; the back end owns the table.
    logic q_valid, q_ready;
    req_t q_req;

    gmt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .node(node), .claimed_state(claimed_state),
        .claimed_incarnation(claimed_incarnation), .claimed_port(claimed_port),
        .now(now), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    gmt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready), .changed(changed),
        .entry_present(entry_present), .entry_state(entry_state),
        .entry_incarnation(entry_incarnation), .entry_port(entry_port),
        .quarantined(quarantined), .alive_count(alive_count),
        .member_count(member_count), .degraded(degraded)
    );
endmodule

/* src/gmt_checker.sv */
`timescale 1ns / 1ps
`include "gossip_membership_table_assert.svh"
module gmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        entry_present,
    input logic [1:0]  entry_state,
    input logic        quarantined,
    input logic [4:0]  alive_count,
    input logic [4:0]  member_count,
    input logic        degraded
);
    import gmt_pkg::*;

    `GMT_ASSERT_IMPL(a_alive_le_members, out_valid, alive_count <= member_count)
    `GMT_ASSERT_IMPL(a_quar_alive, out_valid && quarantined,
        entry_present && entry_state == ST_ALIVE)
    `GMT_ASSERT_IMPL(a_empty_degraded, out_valid && member_count == 5'd0, degraded)
    `GMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind gossip_membership_table gmt_checker u_checker (.*);
